// ----- rtl/him_pkg.sv -----
// hypergraph incidence matrix: shared types and constants
// operation codes, register indexes, field widths and sequencer states
// no dependencies
`default_nettype none

package him_pkg;

    localparam int KIND_W  = 3;
    localparam int ID_W    = 6;
    localparam int COUNT_W = 7;
    localparam int CFG_W   = 7;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

    localparam logic [KIND_W-1:0] KIND_SET    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MEMBER = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DEGREE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SIZE   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RANK   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CORANK = 3'd5;

    localparam logic CFG_VERTEX_COUNT = 1'b0;
    localparam logic CFG_EDGE_COUNT   = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ROW_RD,
        S_ROW_USE,
        S_ROW_BITS,
        S_COL_WALK,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/him_ram.sv -----
// hypergraph incidence matrix: generic simple dual-port ram
// one write port, one read port with registered read data that holds when idle
// no dependencies
`default_nettype none

module him_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic                                       re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hypergraph_incidence_matrix.sv -----
// hypergraph incidence matrix: vertex-by-edge bit store with counting operations
// uses him_pkg (codes, states) and him_ram (one row per vertex)
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_stall   | kind, vertex_id, edge_id
//  out     | output    | out_valid / out_stall | member, count, empty_res, bad_id
//  cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// one row read or one bit per cycle (counts clamped to the store); bad ids skip the ram
// after reset a clearing pass zeroes the ram, in_stall held high
// in_stall stays high while an item is worked on; the next item is taken while the result
// waits in the output register; out_stall holds it, and a later result then waits in S_DONE
`default_nettype none

module hypergraph_incidence_matrix #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [him_pkg::KIND_W-1:0]   kind,
    input  wire logic [him_pkg::ID_W-1:0]     vertex_id,
    input  wire logic [him_pkg::ID_W-1:0]     edge_id,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              member,
    output logic      [him_pkg::COUNT_W-1:0]  count,
    output logic                              empty_res,
    output logic                              bad_id,
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_index,
    input  wire logic [him_pkg::CFG_W-1:0]    cfg_data
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = him_pkg::COUNT_W;

    him_pkg::state_t state_reg, state_next;

    logic [CW-1:0]              vertex_count_reg;
    logic [CW-1:0]              edge_count_reg;
    logic [AW-1:0]              clr_reg, clr_next;
    logic [him_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [him_pkg::ID_W-1:0]   v_reg, v_next;
    logic [him_pkg::ID_W-1:0]   e_reg, e_next;
    logic [CW-1:0]              col_reg, col_next;
    logic [CW-1:0]              row_reg, row_next;
    logic                       pend_reg, pend_next;
    logic [CW-1:0]              sum_reg, sum_next;
    logic [CW-1:0]              best_reg, best_next;
    logic                       res_member_reg, res_member_next;
    logic [CW-1:0]              res_count_reg, res_count_next;
    logic                       res_empty_reg, res_empty_next;
    logic                       res_bad_reg, res_bad_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       out_member_reg, out_member_next;
    logic [CW-1:0]              out_count_reg, out_count_next;
    logic                       out_empty_reg, out_empty_next;
    logic                       out_bad_reg, out_bad_next;

    logic [CW-1:0]        rows;
    logic [CW-1:0]        cols;
    logic                 in_xfer;
    logic                 v_ok;
    logic                 e_ok;
    logic                 out_free;
    logic                 issue;
    logic                 col_end;
    logic                 last_col;
    logic                 add_bit;
    logic [CW-1:0]        sum_inc;
    logic [CW-1:0]        new_best;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [MAX_EDGES-1:0] ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [MAX_EDGES-1:0] ram_rdata;
    logic [MAX_EDGES-1:0] edge_mask;

    him_ram #(
        .WIDTH (MAX_EDGES),
        .DEPTH (MAX_VERTICES)
    ) u_rows (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // active sizes, clamped to the store
    assign rows = (32'(vertex_count_reg) > MAX_VERTICES) ? CW'(MAX_VERTICES) : vertex_count_reg;
    assign cols = (32'(edge_count_reg) > MAX_EDGES) ? CW'(MAX_EDGES) : edge_count_reg;

    assign in_stall  = (state_reg != him_pkg::S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign v_ok      = ({1'b0, vertex_id} < rows);
    assign e_ok      = ({1'b0, edge_id} < cols);
    assign out_free  = !out_valid_reg || !out_stall;
    assign issue     = (row_reg < rows);
    assign col_end   = !issue && !pend_reg;
    assign last_col  = ((col_reg + CW'(1)) == cols);

    // shared unit: saturating bit accumulate and compare
    assign add_bit  = ram_rdata[EW'(col_reg)];
    assign sum_inc  = (sum_reg == him_pkg::COUNT_MAX) ? sum_reg : sum_reg + CW'(add_bit);
    assign new_best = (kind_reg == him_pkg::KIND_RANK)
                      ? ((sum_reg > best_reg) ? sum_reg : best_reg)
                      : ((sum_reg < best_reg) ? sum_reg : best_reg);

    assign out_valid = out_valid_reg;
    assign member    = out_member_reg;
    assign count     = out_count_reg;
    assign empty_res = out_empty_reg;
    assign bad_id    = out_bad_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            him_pkg::S_CLEAR:
            begin
                if (clr_reg == AW'(MAX_VERTICES - 1))
                begin
                    state_next = him_pkg::S_IDLE;
                end
            end
            him_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    case (kind) inside
                        him_pkg::KIND_SET, him_pkg::KIND_MEMBER:
                            state_next = (v_ok && e_ok) ? him_pkg::S_ROW_RD : him_pkg::S_DONE;
                        him_pkg::KIND_DEGREE:
                            state_next = v_ok ? him_pkg::S_ROW_RD : him_pkg::S_DONE;
                        him_pkg::KIND_SIZE:
                            state_next = e_ok ? him_pkg::S_COL_WALK : him_pkg::S_DONE;
                        him_pkg::KIND_RANK, him_pkg::KIND_CORANK:
                            state_next = (cols != '0) ? him_pkg::S_COL_WALK : him_pkg::S_DONE;
                        default:
                            state_next = him_pkg::S_DONE;
                    endcase
                end
            end
            him_pkg::S_ROW_RD:
            begin
                state_next = him_pkg::S_ROW_USE;
            end
            him_pkg::S_ROW_USE:
            begin
                state_next = (kind_reg == him_pkg::KIND_DEGREE) ? him_pkg::S_ROW_BITS
                                                                : him_pkg::S_DONE;
            end
            him_pkg::S_ROW_BITS:
            begin
                if (col_reg >= cols)
                begin
                    state_next = him_pkg::S_DONE;
                end
            end
            him_pkg::S_COL_WALK:
            begin
                if (col_end && (kind_reg == him_pkg::KIND_SIZE || last_col))
                begin
                    state_next = him_pkg::S_DONE;
                end
            end
            him_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = him_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = him_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        clr_next        = clr_reg;
        kind_next       = kind_reg;
        v_next          = v_reg;
        e_next          = e_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        pend_next       = 1'b0;
        sum_next        = sum_reg;
        best_next       = best_reg;
        res_member_next = res_member_reg;
        res_count_next  = res_count_reg;
        res_empty_next  = res_empty_reg;
        res_bad_next    = res_bad_reg;
        out_valid_next  = out_valid_reg;
        out_member_next = out_member_reg;
        out_count_next  = out_count_reg;
        out_empty_next  = out_empty_reg;
        out_bad_next    = out_bad_reg;
        ram_we          = 1'b0;
        ram_waddr       = AW'(v_reg);
        ram_re          = 1'b0;
        ram_raddr       = AW'(v_reg);
        edge_mask       = '0;
        edge_mask[EW'(e_reg)] = 1'b1;
        ram_wdata       = ram_rdata | edge_mask;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            him_pkg::S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + AW'(1);
            end
            him_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    kind_next       = kind;
                    v_next          = vertex_id;
                    e_next          = edge_id;
                    res_member_next = 1'b0;
                    res_count_next  = '0;
                    res_empty_next  = 1'b0;
                    res_bad_next    = 1'b0;
                    row_next        = '0;
                    sum_next        = '0;
                    col_next        = '0;
                    best_next       = '0;
                    case (kind) inside
                        him_pkg::KIND_SET, him_pkg::KIND_MEMBER:
                            res_bad_next = !(v_ok && e_ok);
                        him_pkg::KIND_DEGREE:
                            res_bad_next = !v_ok;
                        him_pkg::KIND_SIZE:
                        begin
                            res_bad_next = !e_ok;
                            col_next     = {1'b0, edge_id};
                        end
                        him_pkg::KIND_CORANK:
                        begin
                            res_empty_next = (cols == '0);
                            best_next      = him_pkg::COUNT_MAX;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            him_pkg::S_ROW_RD:
            begin
                ram_re = 1'b1;
            end
            him_pkg::S_ROW_USE:
            begin
                case (kind_reg)
                    him_pkg::KIND_SET:
                        ram_we = 1'b1;
                    him_pkg::KIND_MEMBER:
                        res_member_next = ram_rdata[EW'(e_reg)];
                    default:
                    begin
                        col_next = '0;
                        sum_next = '0;
                    end
                endcase
            end
            him_pkg::S_ROW_BITS:
            begin
                if (col_reg < cols)
                begin
                    sum_next = sum_inc;
                    col_next = col_reg + CW'(1);
                end
                else
                begin
                    res_count_next = sum_reg;
                end
            end
            him_pkg::S_COL_WALK:
            begin
                ram_raddr = AW'(row_reg);
                if (issue)
                begin
                    ram_re    = 1'b1;
                    row_next  = row_reg + CW'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    sum_next = sum_inc;
                end
                if (col_end)
                begin
                    if (kind_reg == him_pkg::KIND_SIZE)
                    begin
                        res_count_next = sum_reg;
                    end
                    else if (last_col)
                    begin
                        res_count_next = new_best;
                    end
                    else
                    begin
                        best_next = new_best;
                        col_next  = col_reg + CW'(1);
                        row_next  = '0;
                        sum_next  = '0;
                    end
                end
            end
            him_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_member_next = res_member_reg;
                    out_count_next  = res_count_reg;
                    out_empty_next  = res_empty_reg;
                    out_bad_next    = res_bad_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= him_pkg::S_CLEAR;
            clr_reg          <= '0;
            pend_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
            vertex_count_reg <= '0;
            edge_count_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    him_pkg::CFG_VERTEX_COUNT: vertex_count_reg <= cfg_data;
                    him_pkg::CFG_EDGE_COUNT:   edge_count_reg   <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        v_reg          <= v_next;
        e_reg          <= e_next;
        col_reg        <= col_next;
        row_reg        <= row_next;
        sum_reg        <= sum_next;
        best_reg       <= best_next;
        res_member_reg <= res_member_next;
        res_count_reg  <= res_count_next;
        res_empty_reg  <= res_empty_next;
        res_bad_reg    <= res_bad_next;
        out_member_reg <= out_member_next;
        out_count_reg  <= out_count_next;
        out_empty_reg  <= out_empty_next;
        out_bad_reg    <= out_bad_next;
    end

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// testbench for hypergraph_incidence_matrix: random and directed transfers checked
// against a behavioural predictor of the incidence store with random idling on both sides
// depends on rtl/him_pkg.sv and rtl/hypergraph_incidence_matrix.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KIND_W  = him_pkg::KIND_W;
    localparam int ID_W    = him_pkg::ID_W;
    localparam int COUNT_W = him_pkg::COUNT_W;
    localparam int CFG_W   = him_pkg::CFG_W;

    localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;
    localparam int STORE_ROWS = 64;
    localparam int STORE_COLS = 64;
    localparam int LONG_HOLD  = 300;

    typedef struct packed {
        logic               member;
        logic [COUNT_W-1:0] count;
        logic               empty_res;
        logic               bad_id;
    } result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0] vertex_id;
    logic [ID_W-1:0] edge_id;
    logic out_valid;
    logic out_stall;
    logic member;
    logic [COUNT_W-1:0] count;
    logic empty_res;
    logic bad_id;
    logic cfg_we;
    logic cfg_index;
    logic [CFG_W-1:0] cfg_data;

    logic [STORE_COLS-1:0] incidence_bits [STORE_ROWS];
    logic [CFG_W-1:0] vertex_setting;
    logic [CFG_W-1:0] edge_setting;
    result_t awaited_results [$];
    result_t head;
    int error_count = 0;
    int items_sent = 0;
    bit calm = 1'b0;
    bit hold_request = 1'b0;

    hypergraph_incidence_matrix dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .vertex_id(vertex_id),
        .edge_id(edge_id),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .member(member),
        .count(count),
        .empty_res(empty_res),
        .bad_id(bad_id),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int clamp_size(logic [CFG_W-1:0] c, int limit);
        return (int'(c) > limit) ? limit : int'(c);
    endfunction

    function automatic logic [COUNT_W-1:0] clip(int s);
        return (s > int'(him_pkg::COUNT_MAX)) ? him_pkg::COUNT_MAX : COUNT_W'(s);
    endfunction

    function automatic int column_total(int col, int rows);
        int s;
        s = 0;
        for (int r = 0; r < rows; r++)
            s += incidence_bits[r][col];
        return s;
    endfunction

    function automatic result_t apply_operation(logic [KIND_W-1:0] k, logic [ID_W-1:0] v,
                                                logic [ID_W-1:0] e);
        result_t r;
        int rows;
        int cols;
        int s;
        int best;
        bit v_ok;
        bit e_ok;
        r = '0;
        rows = clamp_size(vertex_setting, STORE_ROWS);
        cols = clamp_size(edge_setting, STORE_COLS);
        v_ok = int'(v) < rows;
        e_ok = int'(e) < cols;
        case (k)
            him_pkg::KIND_SET:
                if (v_ok && e_ok)
                    incidence_bits[v][e] = 1'b1;
                else
                    r.bad_id = 1'b1;
            him_pkg::KIND_MEMBER:
                if (v_ok && e_ok)
                    r.member = incidence_bits[v][e];
                else
                    r.bad_id = 1'b1;
            him_pkg::KIND_DEGREE:
                if (v_ok)
                begin
                    s = 0;
                    for (int i = 0; i < cols; i++)
                        s += incidence_bits[v][i];
                    r.count = clip(s);
                end
                else
                    r.bad_id = 1'b1;
            him_pkg::KIND_SIZE:
                if (e_ok)
                    r.count = clip(column_total(e, rows));
                else
                    r.bad_id = 1'b1;
            him_pkg::KIND_RANK:
            begin
                best = 0;
                for (int i = 0; i < cols; i++)
                begin
                    s = column_total(i, rows);
                    if (s > best)
                        best = s;
                end
                r.count = clip(best);
            end
            him_pkg::KIND_CORANK:
                if (cols == 0)
                    r.empty_res = 1'b1;
                else
                begin
                    best = column_total(0, rows);
                    for (int i = 1; i < cols; i++)
                    begin
                        s = column_total(i, rows);
                        if (s < best)
                            best = s;
                    end
                    r.count = clip(best);
                end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, logic [COUNT_W-1:0] want,
                                        logic [COUNT_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t: result with nothing awaited, expected none, actual count %0d",
                         $time, count);
                error_count++;
            end
            else
            begin
                head = awaited_results.pop_front();
                check_field("member", {6'd0, head.member}, {6'd0, member});
                check_field("count", head.count, count);
                check_field("empty_res", {6'd0, head.empty_res}, {6'd0, empty_res});
                check_field("bad_id", {6'd0, head.bad_id}, {6'd0, bad_id});
            end
        end
    end

    // receiver side: random stall bursts and one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic send_item(logic [KIND_W-1:0] k, logic [ID_W-1:0] v, logic [ID_W-1:0] e);
        int gap;
        gap = (calm || $urandom_range(0, 5) != 0) ? 0 : $urandom_range(1, 14);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        vertex_id <= v;
        edge_id <= e;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        awaited_results.push_back(apply_operation(k, v, e));
        items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
    endtask

    task automatic configure(int vc, int ec);
        wait_idle();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= him_pkg::CFG_VERTEX_COUNT;
        cfg_data <= CFG_W'(vc);
        @(negedge clk);
        cfg_index <= him_pkg::CFG_EDGE_COUNT;
        cfg_data <= CFG_W'(ec);
        @(negedge clk);
        cfg_we <= 1'b0;
        vertex_setting = CFG_W'(vc);
        edge_setting = CFG_W'(ec);
    endtask

    function automatic logic [ID_W-1:0] pick_id(int act, bit in_area);
        if (in_area && act > 0)
            return ID_W'($urandom_range(0, act - 1));
        if (act < 64)
            return ID_W'($urandom_range(act, 63));
        return ID_W'($urandom_range(0, 63));
    endfunction

    task automatic run_phase(int n, bit big);
        int pick;
        int heavy;
        int rows;
        int cols;
        heavy = 0;
        rows = clamp_size(vertex_setting, STORE_ROWS);
        cols = clamp_size(edge_setting, STORE_COLS);
        for (int j = 0; j < n; j++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_item(him_pkg::KIND_SET, pick_id(rows, 1'b1), pick_id(cols, 1'b1));
            else if (pick < 66)
                send_item(him_pkg::KIND_MEMBER, pick_id(rows, 1'b1), pick_id(cols, 1'b1));
            else if (pick < 74)
                send_item(him_pkg::KIND_DEGREE, pick_id(rows, 1'b1),
                          ID_W'($urandom_range(0, 63)));
            else if (pick < 82)
                send_item(him_pkg::KIND_SIZE, ID_W'($urandom_range(0, 63)),
                          pick_id(cols, 1'b1));
            else if (pick < 86)
                send_item(KIND_W'($urandom_range(0, 3)), pick_id(rows, 1'b0),
                          pick_id(cols, 1'b0));
            else if (pick < 90)
                send_item(KIND_W'($urandom_range(0, 7)), ID_W'($urandom_range(0, 63)),
                          ID_W'($urandom_range(0, 63)));
            else if (big && heavy >= 2)
                send_item(him_pkg::KIND_MEMBER, pick_id(rows, 1'b1), pick_id(cols, 1'b1));
            else
            begin
                heavy++;
                send_item(($urandom_range(0, 1) == 0) ? him_pkg::KIND_RANK
                                                      : him_pkg::KIND_CORANK,
                          ID_W'($urandom_range(0, 63)), ID_W'($urandom_range(0, 63)));
            end
        end
    endtask

    task automatic test_reset_state();
        send_item(him_pkg::KIND_RANK, 6'd0, 6'd0);
        send_item(him_pkg::KIND_CORANK, 6'd0, 6'd0);
        send_item(him_pkg::KIND_SET, 6'd0, 6'd0);
        send_item(him_pkg::KIND_MEMBER, 6'd63, 6'd63);
        send_item(KIND_SPARE6, 6'd63, 6'd0);
        send_item(KIND_SPARE7, 6'd0, 6'd63);
    endtask

    task automatic test_full_size();
        configure(64, 64);
        send_item(him_pkg::KIND_SET, 6'd0, 6'd0);
        send_item(him_pkg::KIND_SET, 6'd63, 6'd63);
        send_item(him_pkg::KIND_SET, 6'd63, 6'd0);
        send_item(him_pkg::KIND_MEMBER, 6'd63, 6'd63);
        send_item(him_pkg::KIND_MEMBER, 6'd0, 6'd63);
        send_item(him_pkg::KIND_DEGREE, 6'd63, 6'd0);
        send_item(him_pkg::KIND_SIZE, 6'd0, 6'd0);
        send_item(him_pkg::KIND_RANK, 6'd0, 6'd0);
        send_item(him_pkg::KIND_CORANK, 6'd0, 6'd0);
    endtask

    task automatic test_oversize_counts();
        configure(127, 127);
        send_item(him_pkg::KIND_SIZE, 6'd0, 6'd63);
        send_item(him_pkg::KIND_CORANK, 6'd0, 6'd0);
        configure(127, 1);
        send_item(him_pkg::KIND_CORANK, 6'd0, 6'd0);
    endtask

    task automatic test_shrink_and_bad_ids();
        configure(3, 5);
        send_item(him_pkg::KIND_SET, 6'd3, 6'd0);
        send_item(him_pkg::KIND_SET, 6'd0, 6'd5);
        send_item(him_pkg::KIND_DEGREE, 6'd63, 6'd0);
        send_item(him_pkg::KIND_SIZE, 6'd0, 6'd5);
        send_item(him_pkg::KIND_MEMBER, 6'd0, 6'd0);
        configure(64, 64);
        send_item(him_pkg::KIND_MEMBER, 6'd63, 6'd63);
    endtask

    task automatic test_random();
        int sel;
        int vc;
        int ec;
        bit big;
        while (items_sent < 1150)
        begin
            sel = $urandom_range(0, 9);
            big = 1'b0;
            if (sel == 0)
            begin
                vc = ($urandom_range(0, 1) == 0) ? 64 : $urandom_range(65, 127);
                ec = ($urandom_range(0, 1) == 0) ? 64 : $urandom_range(65, 127);
                big = 1'b1;
            end
            else if (sel == 1)
            begin
                vc = ($urandom_range(0, 1) == 0) ? 64 : $urandom_range(1, 12);
                ec = ($urandom_range(0, 1) == 0) ? 64 : $urandom_range(1, 12);
                big = 1'b1;
            end
            else if (sel == 2)
            begin
                vc = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
                ec = (vc == 0) ? $urandom_range(0, 12) : 0;
            end
            else
            begin
                vc = $urandom_range(1, 12);
                ec = $urandom_range(1, 12);
            end
            configure(vc, ec);
            run_phase($urandom_range(30, 80), big);
        end
    endtask

    task automatic test_backpressure();
        configure(8, 8);
        hold_request = 1'b1;
        run_phase(12, 1'b0);
    endtask

    task automatic test_sender_pause();
        configure(6, 10);
        run_phase(10, 1'b0);
        wait_idle();
        run_phase(10, 1'b0);
    endtask

    task automatic test_quiet_tail();
        configure(10, 9);
        calm = 1'b1;
        run_phase(80, 1'b0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = him_pkg::KIND_SET;
        vertex_id = '0;
        edge_id = '0;
        cfg_we = 1'b0;
        cfg_index = him_pkg::CFG_VERTEX_COUNT;
        cfg_data = '0;
        vertex_setting = '0;
        edge_setting = '0;
        for (int r = 0; r < STORE_ROWS; r++)
            incidence_bits[r] = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // clearing pass after reset
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        test_reset_state();
        test_full_size();
        test_oversize_counts();
        test_shrink_and_bad_ids();
        test_random();
        test_backpressure();
        test_sender_pause();
        test_quiet_tail();
        wait_idle();
        repeat (200) @(posedge clk);
        if (error_count == 0 && awaited_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/him_pkg.sv
rtl/him_ram.sv
rtl/hypergraph_incidence_matrix.sv
sim/tb_top.sv
